// ===== design/breakpoint_address_table_assert.svh =====
// Assertion macros shared by the breakpoint address table RTL.
`ifndef BREAKPOINT_ADDRESS_TABLE_ASSERT_SVH
`define BREAKPOINT_ADDRESS_TABLE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bat_pkg.sv =====
// Types and constants of the breakpoint address table.
`timescale 1ns / 1ps
`default_nettype none

package bat_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int ADDR_W     = 64;
  localparam int BYTE_W     = 8;
  localparam int IN_IDX_W   = 10;
  localparam int TOTAL_W    = 11;
  localparam int WIDE_W     = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] orig;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_EXEC
  } state_t;

endpackage

`default_nettype wire

// ===== design/breakpoint_address_table.sv =====
// Breakpoint address table: entry memory, linear search sequencer and result register.
//
// Usage: a request (operation, address, original_byte, entry_index) is
// taken when in_valid is high and in_stall is low; one result (found,
// status, saved_byte, entry_address, point_total) is offered with out_valid
// and transferred when out_stall is low.
// Every request first walks the live entries through one memory read port
// and one 64-bit equality comparator, one entry per cycle, stopping at the
// first match. A delete that hits or an in-range read costs one extra
// memory read after the search. The block holds in_stall high from a
// transfer in until its result sits in the output register, so it works on
// one request at a time and the next transfer in can come once the result
// is loaded.
// A new request is taken while the previous result still waits.
// When the receiver stalls, the result stays in the output register and a
// finished request waits in its final step until that register frees.
// Reset clears the entry count and the handshake state; the entry memory
// is not cleared, since only positions below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "breakpoint_address_table_assert.svh"

module breakpoint_address_table (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [1:0]                  operation,
  input  wire logic [bat_pkg::ADDR_W-1:0]  address,
  input  wire logic [bat_pkg::BYTE_W-1:0]  original_byte,
  input  wire logic [bat_pkg::IN_IDX_W-1:0] entry_index,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic                        found,
  output      logic [1:0]                  status,
  output      logic [bat_pkg::BYTE_W-1:0]  saved_byte,
  output      logic [bat_pkg::ADDR_W-1:0]  entry_address,
  output      logic [bat_pkg::TOTAL_W-1:0] point_total
);

  bat_pkg::state_t state, state_next;

  // Request held for the whole operation.
  logic [1:0]                   op;
  logic [bat_pkg::ADDR_W-1:0]   addr;
  logic [bat_pkg::BYTE_W-1:0]   orig;
  logic [bat_pkg::IN_IDX_W-1:0] idx;

  logic [bat_pkg::CNT_W-1:0] count, count_next;
  logic [bat_pkg::CNT_W-1:0] scan, scan_next;
  logic                      cmp_vld, cmp_vld_next;
  logic [bat_pkg::IDX_W-1:0] cmp_pos, cmp_pos_next;
  logic                      hit, hit_next;
  logic [bat_pkg::IDX_W-1:0] slot, slot_next;
  logic [bat_pkg::BYTE_W-1:0] saved, saved_next;

  // Entry memory, one read and one write port, registered read data.
  bat_pkg::entry_t mem [bat_pkg::MAX_POINTS];
  bat_pkg::entry_t rd_data;
  logic                      mem_re, mem_we;
  logic [bat_pkg::IDX_W-1:0] mem_raddr, mem_waddr;
  bat_pkg::entry_t           mem_wdata;

  logic                        accept, out_free, issuing, match;
  logic                        full, idx_ok;
  logic [bat_pkg::WIDE_W-1:0]  idx_wide, cnt_wide, total_wide;
  logic [1:0]                  status_next;
  logic [bat_pkg::BYTE_W-1:0]  saved_byte_next;
  logic [bat_pkg::ADDR_W-1:0]  entry_address_next;
  logic                        load_out;

  assign in_stall = (state != bat_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign issuing  = (scan < count);
  assign match    = cmp_vld && (rd_data.addr == addr);
  assign full     = (count == bat_pkg::CNT_W'(bat_pkg::MAX_POINTS));
  assign idx_wide = bat_pkg::WIDE_W'(idx);
  assign cnt_wide = bat_pkg::WIDE_W'(count);
  assign idx_ok   = (idx_wide < cnt_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    count_next         = count;
    scan_next          = scan;
    cmp_vld_next       = cmp_vld;
    cmp_pos_next       = cmp_pos;
    hit_next           = hit;
    slot_next          = slot;
    saved_next         = saved;
    mem_re             = 1'b0;
    mem_raddr          = scan[bat_pkg::IDX_W-1:0];
    mem_we             = 1'b0;
    mem_waddr          = slot;
    mem_wdata          = rd_data;
    status_next        = bat_pkg::ST_OK;
    saved_byte_next    = '0;
    entry_address_next = '0;
    load_out           = 1'b0;
    total_wide         = cnt_wide;

    case (state)
      bat_pkg::S_IDLE: begin
        if (accept) begin
          state_next   = bat_pkg::S_SCAN;
          scan_next    = '0;
          cmp_vld_next = 1'b0;
          hit_next     = 1'b0;
          saved_next   = '0;
        end
      end

      bat_pkg::S_SCAN: begin
        // Issue the read of entry scan while comparing the one read last cycle.
        mem_re       = issuing;
        cmp_vld_next = issuing;
        cmp_pos_next = scan[bat_pkg::IDX_W-1:0];
        if (issuing) begin
          scan_next = scan + bat_pkg::CNT_W'(1);
        end
        if (match || !issuing) begin
          hit_next = match;
          if (match) begin
            slot_next  = cmp_pos;
            saved_next = rd_data.orig;
          end
          if ((op == bat_pkg::OP_DELETE && match) || (op == bat_pkg::OP_READ && idx_ok)) begin
            state_next = bat_pkg::S_FETCH;
          end else begin
            state_next = bat_pkg::S_EXEC;
          end
        end
      end

      bat_pkg::S_FETCH: begin
        // A delete reads the last entry to fill the hole; a read fetches its position.
        mem_re = 1'b1;
        if (op == bat_pkg::OP_DELETE) begin
          mem_raddr = bat_pkg::IDX_W'(count - bat_pkg::CNT_W'(1));
        end else begin
          mem_raddr = idx_wide[bat_pkg::IDX_W-1:0];
        end
        state_next = bat_pkg::S_EXEC;
      end

      bat_pkg::S_EXEC: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = bat_pkg::S_IDLE;
          case (op)
            bat_pkg::OP_INSERT: begin
              if (!hit) begin
                if (full) begin
                  status_next = bat_pkg::ST_FULL;
                end else begin
                  mem_we     = 1'b1;
                  mem_waddr  = count[bat_pkg::IDX_W-1:0];
                  mem_wdata  = '{addr: addr, orig: orig};
                  count_next = count + bat_pkg::CNT_W'(1);
                end
              end
            end
            bat_pkg::OP_DELETE: begin
              if (hit) begin
                // Moving the last entry onto itself is harmless when it is the one deleted.
                mem_we          = 1'b1;
                mem_waddr       = slot;
                mem_wdata       = rd_data;
                count_next      = count - bat_pkg::CNT_W'(1);
                saved_byte_next = saved;
              end
            end
            bat_pkg::OP_READ: begin
              if (idx_ok) begin
                entry_address_next = rd_data.addr;
              end else begin
                status_next = bat_pkg::ST_RANGE;
              end
            end
            default: begin
            end
          endcase
          total_wide = bat_pkg::WIDE_W'(count_next);
        end
      end

      default: begin
        state_next = bat_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cmp_vld <= 1'b0;
    end else begin
      count   <= count_next;
      cmp_vld <= cmp_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= operation;
      addr <= address;
      orig <= original_byte;
      idx  <= entry_index;
    end
    scan    <= scan_next;
    cmp_pos <= cmp_pos_next;
    hit     <= hit_next;
    slot    <= slot_next;
    saved   <= saved_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found         <= hit;
      status        <= status_next;
      saved_byte    <= saved_byte_next;
      entry_address <= entry_address_next;
      point_total   <= total_wide[bat_pkg::TOTAL_W-1:0];
    end
  end

  `BAT_ASSERT_NOW(a_count_range, 1'b1, count <= bat_pkg::CNT_W'(bat_pkg::MAX_POINTS), "entry count above table size")
  `BAT_ASSERT_NOW(a_write_in_exec, mem_we, state == bat_pkg::S_EXEC && out_free, "entry memory written outside the final step")
  `BAT_ASSERT_NOW(a_count_only_in_exec, !$stable(count), $past(state == bat_pkg::S_EXEC), "entry count changed outside the final step")
  `BAT_ASSERT_NEXT(a_hit_stops_scan, state == bat_pkg::S_SCAN && match, state != bat_pkg::S_SCAN, "search went on past a matching entry")
  `BAT_ASSERT_NOW(a_result_from_exec, $rose(out_valid), $past(state == bat_pkg::S_EXEC), "result appeared without a finished operation")

endmodule

`default_nettype wire
